// ----- rtl/vpma_pkg.sv -----
// ----------------------------------------------------------------------------
// vpma_pkg
// Types, constants and helper functions of the planar video memory access
// block.
// ----------------------------------------------------------------------------
package vpma_pkg;

  // Configuration register indexes.
  localparam logic [2:0] RegRotateLogic   = 3'd0;
  localparam logic [2:0] RegSetReset      = 3'd1;
  localparam logic [2:0] RegBitMask       = 3'd2;
  localparam logic [2:0] RegGraphicsMode  = 3'd3;
  localparam logic [2:0] RegPlaneWrEn     = 3'd4;
  localparam logic [2:0] RegReadPlane     = 3'd5;
  localparam logic [2:0] RegColorCompare  = 3'd6;
  localparam logic [2:0] RegMemoryMode    = 3'd7;

  localparam logic [6:0] MemoryModeReset = 7'h04;

  // Memory map windows.
  localparam logic [19:0] WinA0000 = 20'hA0000;
  localparam logic [19:0] WinB0000 = 20'hB0000;
  localparam logic [19:0] WinB8000 = 20'hB8000;
  localparam logic [19:0] WinC0000 = 20'hC0000;

  typedef enum logic [1:0] {
    MAP_128K  = 2'd0,
    MAP_64K   = 2'd1,
    MAP_MONO  = 2'd2,
    MAP_COLOR = 2'd3
  } map_sel_e;

  typedef enum logic [1:0] {
    LOP_NONE = 2'd0,
    LOP_AND  = 2'd1,
    LOP_OR   = 2'd2,
    LOP_XOR  = 2'd3
  } logic_op_e;

  typedef enum logic [1:0] {
    WMODE_0 = 2'd0,
    WMODE_1 = 2'd1,
    WMODE_2 = 2'd2,
    WMODE_3 = 2'd3
  } write_mode_e;

  // Replicates one byte into all four planes.
  function automatic logic [31:0] spread(input logic [7:0] b);
    return {b, b, b, b};
  endfunction

  // Expands one bit per plane into a full byte per plane.
  function automatic logic [31:0] fill4(input logic [3:0] bits);
    return {{8{bits[3]}}, {8{bits[2]}}, {8{bits[1]}}, {8{bits[0]}}};
  endfunction

endpackage

// ----- rtl/vga_planar_memory_access_top.sv -----
// ----------------------------------------------------------------------------
// vga_planar_memory_access_top
// CPU byte access to a four-plane video memory: window decode, chain-4,
// odd/even and planar addressing, read modes and write modes 0 to 3.
// ----------------------------------------------------------------------------
// At the edge that accepts an item (start high while busy is low) the address
// is decoded and, on a hit, the four-plane word is read from the plane memory.
// During the following cycle busy is high, the read word is available, and the
// result is presented on hit_o and read_data_o together with the one-cycle
// strobe done_o; a write stores its merged word back at the end of that same
// cycle. No new item is accepted while busy is high, as the read and the write
// of an item share the single port of the plane memory; the next item can be
// accepted at the edge right after the strobe. The receiver cannot stall: a
// result exists only in its strobe cycle and must be taken then. The plane
// memory is not cleared after reset, and reading a word that was never
// written returns undefined data; the data latch resets to zero.
// Configuration registers should be written only while busy is low.
module vga_planar_memory_access_top #(
  parameter int unsigned PLANE_DEPTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [19:0] address_i,
  input  logic [7:0]  write_data_i,
  // Result channel
  output logic        done_o,
  output logic        hit_o,
  output logic [7:0]  read_data_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(PLANE_DEPTH);
  // Width of the index before wrapping; must hold four times the depth.
  localparam int unsigned RW = 19;
  localparam logic [RW-1:0] Depth1 = RW'(PLANE_DEPTH);
  localparam logic [RW-1:0] Depth2 = RW'(2 * PLANE_DEPTH);
  localparam logic [RW-1:0] Depth4 = RW'(4 * PLANE_DEPTH);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [4:0] rotate_and_logic_q;
  logic [7:0] set_reset_enable_q;
  logic [7:0] bit_mask_q;
  logic [3:0] graphics_mode_q;
  logic [3:0] plane_write_enable_q;
  logic [1:0] read_plane_select_q;
  logic [7:0] color_compare_care_q;
  logic [6:0] memory_mode_q;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotate_and_logic_q   <= '0;
      set_reset_enable_q   <= '0;
      bit_mask_q           <= '0;
      graphics_mode_q      <= '0;
      plane_write_enable_q <= '0;
      read_plane_select_q  <= '0;
      color_compare_care_q <= '0;
      memory_mode_q        <= vpma_pkg::MemoryModeReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        vpma_pkg::RegRotateLogic:  rotate_and_logic_q   <= pwdata[4:0];
        vpma_pkg::RegSetReset:     set_reset_enable_q   <= pwdata[7:0];
        vpma_pkg::RegBitMask:      bit_mask_q           <= pwdata[7:0];
        vpma_pkg::RegGraphicsMode: graphics_mode_q      <= pwdata[3:0];
        vpma_pkg::RegPlaneWrEn:    plane_write_enable_q <= pwdata[3:0];
        vpma_pkg::RegReadPlane:    read_plane_select_q  <= pwdata[1:0];
        vpma_pkg::RegColorCompare: color_compare_care_q <= pwdata[7:0];
        vpma_pkg::RegMemoryMode:   memory_mode_q        <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      vpma_pkg::RegRotateLogic:  prdata = 32'(rotate_and_logic_q);
      vpma_pkg::RegSetReset:     prdata = 32'(set_reset_enable_q);
      vpma_pkg::RegBitMask:      prdata = 32'(bit_mask_q);
      vpma_pkg::RegGraphicsMode: prdata = 32'(graphics_mode_q);
      vpma_pkg::RegPlaneWrEn:    prdata = 32'(plane_write_enable_q);
      vpma_pkg::RegReadPlane:    prdata = 32'(read_plane_select_q);
      vpma_pkg::RegColorCompare: prdata = 32'(color_compare_care_q);
      vpma_pkg::RegMemoryMode:   prdata = 32'(memory_mode_q);
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Address decode, done in the accept cycle
  // --------------------------------------------------------------------------
  logic                     accept;
  logic [19:0]              win_start;
  logic [19:0]              win_end;
  logic                     hit_d;
  logic [16:0]              off;
  logic [3:0]               planes_d;
  logic [RW-1:0]            real_idx;
  logic [RW-1:0]            red;
  logic [AW-1:0]            idx_d;
  logic                     odd_even;
  vpma_pkg::map_sel_e       map_sel;

  assign accept  = start & ~busy;
  assign map_sel = vpma_pkg::map_sel_e'(memory_mode_q[1:0]);

  always_comb begin
    case (map_sel)
      vpma_pkg::MAP_128K: begin
        win_start = vpma_pkg::WinA0000;
        win_end   = vpma_pkg::WinC0000;
      end
      vpma_pkg::MAP_64K: begin
        win_start = vpma_pkg::WinA0000;
        win_end   = vpma_pkg::WinB0000;
      end
      vpma_pkg::MAP_MONO: begin
        win_start = vpma_pkg::WinB0000;
        win_end   = vpma_pkg::WinB8000;
      end
      default: begin
        win_start = vpma_pkg::WinB8000;
        win_end   = vpma_pkg::WinC0000;
      end
    endcase
  end

  assign hit_d = memory_mode_q[2] & (address_i >= win_start) & (address_i < win_end);
  assign off   = 17'(address_i - win_start);

  // Odd/even addressing applies to writes unless disabled, and to reads
  // when the graphics mode asks for it.
  assign odd_even = (func_i & ~memory_mode_q[4]) | (~func_i & graphics_mode_q[3]);

  always_comb begin
    if (memory_mode_q[3]) begin
      planes_d = 4'b0001 << off[1:0];
      real_idx = RW'({off[16:2], 2'b00});
    end else if (odd_even) begin
      planes_d = off[0] ? 4'b1010 : 4'b0101;
      real_idx = RW'(off);
      if (memory_mode_q[5]) begin
        real_idx = RW'({off[15:1], off[16]});
      end
      if (memory_mode_q[6] && off[16]) begin
        real_idx[1] = 1'b1;
      end
    end else begin
      planes_d = func_i ? 4'b1111 : (4'b0001 << read_plane_select_q);
      real_idx = RW'(off);
    end
  end

  // Wrap the index into the plane memory; the quotient is below eight, so
  // three conditional subtractions are enough.
  always_comb begin
    red = real_idx;
    if (red >= Depth4) begin
      red = red - Depth4;
    end
    if (red >= Depth2) begin
      red = red - Depth2;
    end
    if (red >= Depth1) begin
      red = red - Depth1;
    end
  end

  assign idx_d = red[AW-1:0];

  // --------------------------------------------------------------------------
  // Write data path, computed from the CPU byte and the latch
  // --------------------------------------------------------------------------
  logic [31:0]             data_latch_q;
  logic [7:0]              rot;
  logic [15:0]             rot_wide;
  logic [31:0]             sr_fill;
  logic [31:0]             base;
  logic [31:0]             alu;
  logic [7:0]              mask;
  logic [31:0]             mask_w;
  logic [31:0]             wdata_d;
  vpma_pkg::logic_op_e     lop;
  vpma_pkg::write_mode_e   wmode;

  assign rot_wide = {write_data_i, write_data_i} >> rotate_and_logic_q[2:0];
  assign rot      = rot_wide[7:0];
  assign sr_fill  = vpma_pkg::fill4(set_reset_enable_q[3:0]);
  assign lop      = vpma_pkg::logic_op_e'(rotate_and_logic_q[4:3]);
  assign wmode    = vpma_pkg::write_mode_e'(graphics_mode_q[1:0]);

  always_comb begin
    case (wmode)
      vpma_pkg::WMODE_0: begin
        base = (vpma_pkg::spread(rot) & ~vpma_pkg::fill4(set_reset_enable_q[7:4]))
             | (sr_fill & vpma_pkg::fill4(set_reset_enable_q[7:4]));
        mask = bit_mask_q;
      end
      vpma_pkg::WMODE_2: begin
        base = vpma_pkg::fill4(write_data_i[3:0]);
        mask = bit_mask_q;
      end
      vpma_pkg::WMODE_3: begin
        base = sr_fill;
        mask = rot & bit_mask_q;
      end
      default: begin
        base = data_latch_q;
        mask = 8'hFF;
      end
    endcase
  end

  always_comb begin
    case (lop)
      vpma_pkg::LOP_AND: alu = base & data_latch_q;
      vpma_pkg::LOP_OR:  alu = base | data_latch_q;
      vpma_pkg::LOP_XOR: alu = base ^ data_latch_q;
      default:           alu = base;
    endcase
  end

  assign mask_w = vpma_pkg::spread(mask);
  // Write mode 1 copies the latch unchanged.
  assign wdata_d = (wmode == vpma_pkg::WMODE_1) ? data_latch_q
                 : ((alu & mask_w) | (data_latch_q & ~mask_w));

  // --------------------------------------------------------------------------
  // Access stage registers
  // --------------------------------------------------------------------------
  logic          busy_q;
  logic          hit_q;
  logic          wr_q;
  logic [3:0]    planes_q;
  logic [AW-1:0] idx_q;
  logic [31:0]   wdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      hit_q  <= 1'b0;
      wr_q   <= 1'b0;
    end else begin
      busy_q <= accept;
      if (accept) begin
        hit_q <= hit_d;
        wr_q  <= func_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      planes_q <= planes_d;
      idx_q    <= idx_d;
      wdata_q  <= wdata_d;
    end
  end

  assign busy = busy_q;

  // --------------------------------------------------------------------------
  // Plane memory: read at accept, merged write-back in the following cycle
  // --------------------------------------------------------------------------
  logic [31:0] plane_mem [PLANE_DEPTH];
  logic [31:0] rdata_q;
  logic [3:0]  en;
  logic [31:0] en_w;
  logic [31:0] merged;
  logic        mem_wr;
  logic        rd_hit;

  assign en     = plane_write_enable_q & planes_q;
  assign en_w   = vpma_pkg::fill4(en);
  assign merged = (wdata_q & en_w) | (rdata_q & ~en_w);
  assign mem_wr = busy_q & hit_q & wr_q;
  assign rd_hit = busy_q & hit_q & ~wr_q;

  always_ff @(posedge clk_i) begin
    if (accept && hit_d) begin
      rdata_q <= plane_mem[idx_d];
    end
    if (mem_wr) begin
      plane_mem[idx_q] <= merged;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_latch_q <= '0;
    end else if (rd_hit) begin
      data_latch_q <= rdata_q;
    end
  end

  // --------------------------------------------------------------------------
  // Read result
  // --------------------------------------------------------------------------
  logic [31:0] diff;
  logic [7:0]  cmp_byte;
  logic [7:0]  plane_byte;

  assign diff     = (rdata_q ^ vpma_pkg::fill4(color_compare_care_q[3:0]))
                  & vpma_pkg::fill4(color_compare_care_q[7:4]);
  assign cmp_byte = ~(diff[7:0] | diff[15:8] | diff[23:16] | diff[31:24]);

  // Lowest selected plane.
  always_comb begin
    if (planes_q[0]) begin
      plane_byte = rdata_q[7:0];
    end else if (planes_q[1]) begin
      plane_byte = rdata_q[15:8];
    end else if (planes_q[2]) begin
      plane_byte = rdata_q[23:16];
    end else begin
      plane_byte = rdata_q[31:24];
    end
  end

  assign done_o      = busy_q;
  assign hit_o       = busy_q & hit_q;
  assign read_data_o = rd_hit ? (graphics_mode_q[2] ? cmp_byte : plane_byte) : 8'h00;

`ifndef SYNTH
  // A result strobe follows exactly one accepted item.
  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result without accepted item");

  // Items are processed one at a time: busy high is always followed by busy low.
  a_busy_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held for two cycles");

  // Misses and writes return zero read data.
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (!hit_o || wr_q)) |-> (read_data_o == 8'h00))
    else $error("nonzero read data on miss or write");

  // Writes never load the data latch.
  a_latch_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && wr_q) |=> $stable(data_latch_q))
    else $error("data latch changed by a write");
`endif

endmodule
